### sv/tect_pkg.sv
// Package for the tensor element converter: constants, codes and the F16/BF16 widening function.
// No dependencies.
`timescale 1ns / 1ps
package tect_pkg;
  localparam int MaxDimDefault = 64;
  localparam int StoreDepthDefault = 4096;
  localparam int CntW = 13;

  localparam logic [1:0] DT_F32  = 2'd0;
  localparam logic [1:0] DT_F16  = 2'd1;
  localparam logic [1:0] DT_BF16 = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [1:0] REG_DTYPE = 2'd0;
  localparam logic [1:0] REG_TRANS = 2'd1;
  localparam logic [1:0] REG_ROWS  = 2'd2;
  localparam logic [1:0] REG_COLS  = 2'd3;

  typedef struct packed {
    logic       load_store;
    logic       read_store;
    logic       emit_direct;
    logic       emit_error;
    logic       last;
    logic [1:0] status;
  } ctrl_cmd_t;

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [31:0] sign;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  lz;
    logic [10:0] sh;
    logic [7:0]  e8;
    begin
      sign = {h[15], 31'd0};
      ex = h[14:10];
      man = h[9:0];
      lz = 4'd0;
      for (int k = 0; k < 10; k++) begin
        if (man[k]) lz = 4'(9 - k);
      end
      if (ex == 5'd0) begin
        if (man == 10'd0) begin
          half_to_single = sign;
        end else begin
          sh = {1'b0, man} << (lz + 4'd1);
          e8 = 8'(8'd112 - {4'd0, lz});
          half_to_single = sign | {1'b0, e8, sh[9:0], 13'd0};
        end
      end else if (ex == 5'h1f) begin
        half_to_single = sign | 32'h7f800000 | {9'd0, man, 13'd0};
      end else begin
        half_to_single = sign | {1'b0, 8'({3'd0, ex} + 8'd112), man, 13'd0};
      end
    end
  endfunction

  function automatic logic [31:0] convert_word(input logic [1:0] dt, input logic [31:0] w);
    begin
      case (dt)
        DT_F16:  convert_word = half_to_single(w[15:0]);
        DT_BF16: convert_word = {w[15:0], 16'd0};
        default: convert_word = w;
      endcase
    end
  endfunction
endpackage

### sv/tect_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module tect_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[addr_i];
  end
endmodule

### sv/tect_ctrl.sv
// Controller: counters, fill and fetch sequencing, status decisions.
// Depends on tect_pkg.
`timescale 1ns / 1ps
module tect_ctrl #(
  parameter int MaxDim = tect_pkg::MaxDimDefault,
  parameter int StoreDepth = tect_pkg::StoreDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_i,
  input  logic                          command_i,
  input  logic                          trans_i,
  input  logic [6:0]                    rows_raw_i,
  input  logic [6:0]                    cols_raw_i,
  output tect_pkg::ctrl_cmd_t           cmd_o,
  output logic [$clog2(StoreDepth)-1:0] addr_o
);
  import tect_pkg::*;
  localparam int AW = $clog2(StoreDepth);
  localparam int DW = $clog2(MaxDim + 1);
  localparam int TW = 2 * DW;

  logic [DW-1:0] rows, cols;
  logic [TW-1:0] total;
  logic [TW-1:0] load_q, load_d, emit_q, emit_d;
  logic [DW-1:0] row_q, row_d, col_q, col_d;
  logic full_q, full_d;
  logic [TW-1:0] raddr;
  logic [TW:0] ninc_l, ninc_e;

  function automatic logic [DW-1:0] clamp(input logic [6:0] d);
    begin
      if (d == 7'd0) clamp = DW'(1);
      else if ({25'd0, d} > 32'(MaxDim)) clamp = DW'(MaxDim);
      else clamp = DW'(d);
    end
  endfunction

  always_comb begin
    rows = clamp(rows_raw_i);
    cols = clamp(cols_raw_i);
    total = TW'(rows) * TW'(cols);
    raddr = TW'(row_q) * TW'(cols) + TW'(col_q);
    ninc_l = {1'b0, load_q} + 1'b1;
    ninc_e = {1'b0, emit_q} + 1'b1;
    load_d = load_q; emit_d = emit_q; row_d = row_q; col_d = col_q; full_d = full_q;
    cmd_o = '0;
    addr_o = AW'(load_q);
    if (req_i) begin
      if (command_i == CMD_LOAD) begin
        if (full_q) begin
          cmd_o.emit_error = 1'b1;
          cmd_o.status = ST_FULL;
        end else if (!trans_i) begin
          cmd_o.emit_direct = 1'b1;
          if (ninc_l >= {1'b0, total}) begin
            cmd_o.last = 1'b1;
            load_d = '0;
          end else begin
            load_d = ninc_l[TW-1:0];
          end
        end else begin
          cmd_o.load_store = 1'b1;
          load_d = ninc_l[TW-1:0];
          if (ninc_l >= {1'b0, total}) full_d = 1'b1;
        end
      end else if (!full_q) begin
        cmd_o.emit_error = 1'b1;
        cmd_o.status = ST_NONE;
      end else begin
        cmd_o.read_store = 1'b1;
        addr_o = AW'(raddr);
        if (ninc_e >= {1'b0, total}) begin
          cmd_o.last = 1'b1;
          emit_d = '0; row_d = '0; col_d = '0; load_d = '0; full_d = 1'b0;
        end else begin
          emit_d = ninc_e[TW-1:0];
          if (row_q + 1'b1 >= rows) begin
            row_d = '0;
            col_d = (col_q + 1'b1 >= cols) ? '0 : DW'(col_q + 1'b1);
          end else begin
            row_d = DW'(row_q + 1'b1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0; emit_q <= '0; row_q <= '0; col_q <= '0; full_q <= 1'b0;
    end else begin
      load_q <= load_d; emit_q <= emit_d; row_q <= row_d; col_q <= col_d; full_q <= full_d;
    end
  end
endmodule

### sv/tect_dp.sv
// Datapath: format conversion, element store and result register.
// Depends on tect_pkg and tect_ram.
`timescale 1ns / 1ps
module tect_dp #(
  parameter int StoreDepth = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tect_pkg::ctrl_cmd_t           cmd_i,
  input  logic [$clog2(StoreDepth)-1:0] addr_i,
  input  logic [1:0]                    dtype_i,
  input  logic [31:0]                   raw_word_i,
  output logic                          valid_o,
  output logic [31:0]                   value_bits_o,
  output logic                          last_of_tensor_o,
  output logic [1:0]                    status_o
);
  import tect_pkg::*;
  logic [31:0] conv, rdata;
  logic [31:0] direct_q, direct_d;
  logic sel_q, valid_q, last_q;
  logic [1:0] status_q;

  assign conv = convert_word(dtype_i, raw_word_i);
  assign direct_d = cmd_i.emit_direct ? conv : 32'd0;

  tect_ram #(.Width(32), .Depth(StoreDepth)) u_ram (
    .clk_i(clk_i), .we_i(cmd_i.load_store), .re_i(cmd_i.read_store),
    .addr_i(addr_i), .wdata_i(conv), .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    direct_q <= direct_d;
    last_q <= cmd_i.last;
    status_q <= cmd_i.status;
    sel_q <= cmd_i.read_store;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= cmd_i.emit_direct | cmd_i.emit_error | cmd_i.read_store;
  end

  assign valid_o = valid_q;
  assign value_bits_o = sel_q ? rdata : direct_q;
  assign last_of_tensor_o = last_q;
  assign status_o = status_q;
endmodule

### sv/tensor_element_convert_transpose.sv
// Top level of the tensor element converter with optional transpose.
// Depends on tect_pkg, tect_ctrl, tect_dp and tect_ram.
`timescale 1ns / 1ps
// Each request is taken as it comes and busy stays low, so a new request may come every
// cycle. A result appears on the cycle after its request, held for that one cycle and marked by
// done_o; the receiver cannot stall. Results are registered; a fetch uses the registered read of the
// single-port element store. A transposed load gives no result unless the store is full (ST_FULL).
module tensor_element_convert_transpose #(
  parameter int MaxDim = tect_pkg::MaxDimDefault,
  parameter int StoreDepth = tect_pkg::StoreDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        command_i,
  input  logic [31:0] raw_word_i,
  output logic        done_o,
  output logic [31:0] value_bits_o,
  output logic        last_of_tensor_o,
  output logic [1:0]  status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tect_pkg::*;
  logic [1:0] dtype_q;
  logic trans_q;
  logic [6:0] rows_q, cols_q;
  ctrl_cmd_t cmd;
  logic [$clog2(StoreDepth)-1:0] addr;
  logic wr;

  assign busy = 1'b0;
  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dtype_q <= DT_F32; trans_q <= 1'b0; rows_q <= 7'd1; cols_q <= 7'd1;
    end else if (wr) begin
      case (paddr[3:2])
        REG_DTYPE: dtype_q <= pwdata[1:0];
        REG_TRANS: trans_q <= pwdata[0];
        REG_ROWS:  rows_q <= pwdata[6:0];
        REG_COLS:  cols_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DTYPE: prdata = {30'd0, dtype_q};
      REG_TRANS: prdata = {31'd0, trans_q};
      REG_ROWS:  prdata = {25'd0, rows_q};
      REG_COLS:  prdata = {25'd0, cols_q};
      default:   prdata = 32'd0;
    endcase
  end

  tect_ctrl #(.MaxDim(MaxDim), .StoreDepth(StoreDepth)) u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(start & ~busy), .command_i(command_i),
    .trans_i(trans_q), .rows_raw_i(rows_q), .cols_raw_i(cols_q), .cmd_o(cmd), .addr_o(addr)
  );

  tect_dp #(.StoreDepth(StoreDepth)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .addr_i(addr), .dtype_i(dtype_q),
    .raw_word_i(raw_word_i), .valid_o(done_o), .value_bits_o(value_bits_o),
    .last_of_tensor_o(last_of_tensor_o), .status_o(status_o)
  );
endmodule

### test/tect_checker.sv
// Checker for the tensor element converter: watches requests, config writes and results,
// predicts each result and compares it. Depends on tect_pkg.
`timescale 1ns / 1ps
module tect_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic        command_i,
  input  logic [31:0] raw_word_i,
  input  logic        done_o,
  input  logic [31:0] value_bits_o,
  input  logic        last_of_tensor_o,
  input  logic [1:0]  status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending_count
);
  import tect_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic [1:0]  status;
  } elem_result_t;

  elem_result_t expected_q[$];
  logic [31:0] elem_mem [4096];
  int unsigned n_loaded, e_row, e_col, n_emitted;
  bit          mem_full;
  logic [1:0]  cfg_dtype;
  logic        cfg_trans;
  logic [6:0]  cfg_rows, cfg_cols;

  function automatic int unsigned dim_of(logic [6:0] d);
    if (d == 0) return 1;
    if (d > 64) return 64;
    return d;
  endfunction

  function automatic logic [31:0] widen_half(logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0]  ex;
    logic [10:0] man;
    int          e;
    sgn = {h[15], 31'd0};
    ex = h[14:10];
    man = {1'b0, h[9:0]};
    e = 1;
    if (ex == 0) begin
      if (man == 0) return sgn;
      while (!man[10]) begin
        man = man << 1;
        e--;
      end
      return sgn | (32'(e + 112) << 23) | (32'(man[9:0]) << 13);
    end
    if (ex == 5'h1f) return sgn | 32'h7f800000 | (32'(man[9:0]) << 13);
    return sgn | (32'(ex + 112) << 23) | (32'(man[9:0]) << 13);
  endfunction

  function automatic logic [31:0] to_single(logic [31:0] w);
    if (cfg_dtype == DT_F16) return widen_half(w[15:0]);
    if (cfg_dtype == DT_BF16) return {w[15:0], 16'd0};
    return w;
  endfunction

  task automatic predict_request(logic cmd, logic [31:0] w);
    int unsigned rows, cols, total;
    elem_result_t r;
    rows = dim_of(cfg_rows);
    cols = dim_of(cfg_cols);
    total = rows * cols;
    r = '0;
    if (cmd == CMD_LOAD) begin
      if (mem_full) begin
        r.status = ST_FULL;
        expected_q.insert(expected_q.size(), r);
      end else if (!cfg_trans) begin
        r.value = to_single(w);
        n_loaded++;
        if (n_loaded >= total) begin
          r.last = 1'b1;
          n_loaded = 0;
        end
        expected_q.insert(expected_q.size(), r);
      end else begin
        elem_mem[n_loaded % 4096] = to_single(w);
        n_loaded++;
        if (n_loaded >= total) mem_full = 1;
      end
    end else if (!mem_full) begin
      r.status = ST_NONE;
      expected_q.insert(expected_q.size(), r);
    end else begin
      r.value = elem_mem[(e_row * cols + e_col) % 4096];
      n_emitted++;
      if (n_emitted >= total) begin
        r.last = 1'b1;
        n_emitted = 0;
        e_row = 0;
        e_col = 0;
        n_loaded = 0;
        mem_full = 0;
      end else begin
        e_row++;
        if (e_row >= rows) begin
          e_row = 0;
          e_col++;
          if (e_col >= cols) e_col = 0;
        end
      end
      expected_q.insert(expected_q.size(), r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    elem_result_t exp_r;
    if (!rst_ni) begin
      fail_count <= 0;
      pending_count <= 0;
      expected_q.delete();
      n_loaded = 0;
      e_row = 0;
      e_col = 0;
      n_emitted = 0;
      mem_full = 0;
      cfg_dtype = DT_F32;
      cfg_trans = 1'b0;
      cfg_rows = 7'd1;
      cfg_cols = 7'd1;
    end else begin
      if (done_o) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result value=%h last=%b status=%0d", $time,
                   value_bits_o, last_of_tensor_o, status_o);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r !== {value_bits_o, last_of_tensor_o, status_o}) begin
            $display("%0t: mismatch expected value=%h last=%b status=%0d, actual value=%h last=%b status=%0d",
                     $time, exp_r.value, exp_r.last, exp_r.status,
                     value_bits_o, last_of_tensor_o, status_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_DTYPE: cfg_dtype = pwdata[1:0];
          REG_TRANS: cfg_trans = pwdata[0];
          REG_ROWS:  cfg_rows = pwdata[6:0];
          default:   cfg_cols = pwdata[6:0];
        endcase
      end
      if (start && !busy) predict_request(command_i, raw_word_i);
      pending_count <= expected_q.size();
    end
  end
endmodule

### test/tb.sv
// Testbench top for the tensor element converter: drives config writes and requests,
// and reports the verdict. Depends on tect_pkg, tect_checker and the block.
`timescale 1ns / 1ps
module tb;
  import tect_pkg::*;

  logic        clk_i, rst_ni, start, busy, command_i, done_o, last_of_tensor_o;
  logic        psel, penable, pwrite, pready;
  logic [31:0] raw_word_i, value_bits_o, pwdata, prdata;
  logic [1:0]  status_o;
  logic [3:0]  paddr;
  int          fail_count, pending_count;
  int          idle_pct;
  logic [1:0]  cur_dtype;
  logic        cur_trans;
  int          cur_rows, cur_cols;

  tensor_element_convert_transpose dut (.*);
  tect_checker checker_i (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    paddr <= {idx, 2'b00};
    pwdata <= val;
    pwrite <= 1'b1;
    psel <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_request(logic cmd, logic [31:0] w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    command_i <= cmd;
    raw_word_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic quiesce();
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic configure(logic [1:0] dt, logic tr, int rows, int cols);
    quiesce();
    write_reg(REG_DTYPE, 32'(dt));
    write_reg(REG_TRANS, 32'(tr));
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
    cur_dtype = dt;
    cur_trans = tr;
    cur_rows = rows;
    cur_cols = cols;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return {$urandom_range(1) ? 16'hffff : 16'h0, 1'b0, 5'h1f, 10'($urandom)};
      1: return {16'($urandom), 1'b0, 5'h00, 10'($urandom)};
      2: return 32'hffffffff;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // Loads a whole tensor and, when transposing, then fetches it back, with some stray requests mixed in.
  task automatic random_tensor();
    int total;
    total = (cur_rows < 1 ? 1 : cur_rows > 64 ? 64 : cur_rows) *
            (cur_cols < 1 ? 1 : cur_cols > 64 ? 64 : cur_cols);
    for (int k = 0; k < total; k++) begin
      if ($urandom_range(19) == 0) send_request(CMD_FETCH, $urandom);
      send_request(CMD_LOAD, rand_word());
    end
    if (cur_trans) begin
      if ($urandom_range(3) == 0) send_request(CMD_LOAD, $urandom);
      for (int k = 0; k < total; k++) send_request(CMD_FETCH, $urandom);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    command_i = CMD_LOAD;
    raw_word_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    configure(DT_F16, 1'b0, 1, 4);
    send_request(CMD_LOAD, 32'h0000_0000);
    send_request(CMD_LOAD, 32'hffff_8001);
    send_request(CMD_LOAD, 32'h0000_7c00);
    send_request(CMD_LOAD, 32'h0000_fe01);
    send_request(CMD_LOAD, 32'h0000_03ff);
    send_request(CMD_FETCH, 32'hffff_ffff);
    configure(2'd3, 1'b0, 0, 0);
    send_request(CMD_LOAD, 32'hdead_beef);
    configure(DT_BF16, 1'b1, 2, 3);
    send_request(CMD_FETCH, 32'h0);
    for (int k = 0; k < 6; k++) send_request(CMD_LOAD, 32'h1234_0000 + k);
    send_request(CMD_LOAD, 32'hffff_ffff);
    for (int k = 0; k < 6; k++) send_request(CMD_FETCH, 32'h0);
    configure(DT_F32, 1'b1, 127, 1);
    random_tensor();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 25 : (ph == 1) ? 71 : 0;
      for (int t = 0; t < 5; t++) begin
        configure(2'($urandom_range(3)), 1'($urandom_range(1)),
                  $urandom_range(3) == 0 ? $urandom_range(5, 8) : $urandom_range(0, 4),
                  $urandom_range(3) == 0 ? $urandom_range(9, 16) : $urandom_range(1, 4));
        random_tensor();
      end
    end
    configure(DT_F16, 1'b1, 64, 64);
    quiesce();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
